// ===== design/ifb_pkg.sv =====
// ----------------------------------------------------------------------------
// Interframe blend filter package
// Shared constants, register indexes and store rotation helper.
// ----------------------------------------------------------------------------
package ifb_pkg;

    localparam int MAX_FRAME_PIXELS_DEF = 131072;
    localparam int PIXEL_BITS_DEF       = 32;
    localparam int CFG_W                = 32;
    localparam int CFG_IDX_W            = 2;
    localparam int FRAME_W              = 18;
    localparam int PORT_PIX_W           = 32;

    localparam logic [CFG_W-1:0]   MASK_RESET  = 32'h00fe_fefe;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 18'd38400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE   = 2'd0,
        CFG_COLOR_MASK   = 2'd1,
        CFG_FRAME_PIXELS = 2'd2
    } t_cfg_idx;

    typedef logic [1:0] t_store_sel;

    localparam logic [1:0] ROLE_BACK1 = 2'd0;
    localparam logic [1:0] ROLE_BACK2 = 2'd1;
    localparam logic [1:0] ROLE_BACK3 = 2'd2;

    // Physical store that holds the frame of the given role.
    function automatic t_store_sel store_of(input logic [1:0] rot, input logic [1:0] role);
        logic [2:0] sum;
        sum = 3'(rot) + 3'(role);
        if (sum >= 3'd3) begin
            sum = sum - 3'd3;
        end
        return t_store_sel'(sum[1:0]);
    endfunction

endpackage

// ===== design/interframe_blend_filter.sv =====
// ----------------------------------------------------------------------------
// Interframe blend filter
// Smart flicker blending or motion blur over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on i_pixel_in with i_in_valid and are taken when o_in_stall is
// low. Each transfer yields one result on o_pixel_out and o_frame_last, shown
// with o_out_valid and taken when i_out_stall is low. A result is registered
// in the compute stage, then in the output register; one pixel per cycle is
// sustained while the receiver does not stall. Three frame memories of
// MAX_FRAME_PIXELS words (131072 by default) hold past frames; all are read
// when a pixel is taken, and one is written when its result moves to the
// output register, with a bypass for a write at the same address. After reset
// they are cleared while o_in_stall is high. Registers may be written then.
// When the receiver stalls, the output register holds its result, one more
// pixel waits in the compute stage, and then o_in_stall rises.
// Registers are written through i_cfg_we, i_cfg_addr and i_cfg_data; the user
// must do so only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module interframe_blend_filter #(
    parameter int MAX_FRAME_PIXELS = ifb_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int PIXEL_BITS       = ifb_pkg::PIXEL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ifb_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ifb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ifb_pkg::PORT_PIX_W-1:0] i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ifb_pkg::PORT_PIX_W-1:0] o_pixel_out,
    output logic                           o_frame_last
);
    import ifb_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME_PIXELS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int CMP_W  = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_FRAME_PIXELS);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_FRAME_PIXELS - 1);

    logic                  r_blend_mode;
    logic [CFG_W-1:0]      r_color_mask;
    logic [FRAME_W-1:0]    r_frame_pixels;

    logic [ADDR_W-1:0]     r_pos;
    logic [1:0]            r_rot;
    logic                  r_clr_busy;
    logic [ADDR_W-1:0]     r_clr_addr;

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [1:0]            r_s1_rot;
    logic                  r_s1_mode;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s1_last;
    t_store_sel            r_s1_wsel;
    logic [2:0]            r_hit;
    logic [PIXEL_BITS-1:0] r_fwd;
    logic [PIXEL_BITS-1:0] r_rd [3];

    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic                  r_out_last;

    logic                  s1_adv;
    logic                  in_acc;
    logic [CMP_W-1:0]      fp_eff;
    logic [CMP_W-1:0]      pos_inc;
    logic                  is_last;
    logic [ADDR_W-1:0]     n_pos;
    logic [1:0]            n_rot;
    t_store_sel            n_wsel;
    logic [2:0]            wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_BITS-1:0] wr_data;
    logic [2:0]            n_hit;
    logic [PIXEL_BITS-1:0] p_phys [3];
    logic [PIXEL_BITS-1:0] p1;
    logic [PIXEL_BITS-1:0] p2;
    logic [PIXEL_BITS-1:0] p3;
    logic [PIXEL_BITS-1:0] mask;
    logic [PIXEL_BITS-1:0] avg;
    logic                  flicker;
    logic [PIXEL_BITS-1:0] n_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode   <= 1'b0;
            r_color_mask   <= MASK_RESET;
            r_frame_pixels <= FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_BLEND_MODE:   r_blend_mode   <= i_cfg_data[0];
                CFG_COLOR_MASK:   r_color_mask   <= i_cfg_data;
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data[FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s1_adv     = r_s1_valid & (~r_out_valid | ~i_out_stall);
        o_in_stall = r_clr_busy | (r_s1_valid & ~s1_adv);
        in_acc     = i_in_valid & ~o_in_stall;

        fp_eff = CMP_W'(r_frame_pixels);
        if (fp_eff == '0) begin
            fp_eff = CMP_W'(1);
        end else if (fp_eff > MAX_CMP) begin
            fp_eff = MAX_CMP;
        end
        pos_inc = CMP_W'(r_pos) + CMP_W'(1);
        is_last = (pos_inc >= fp_eff);
        n_pos   = is_last ? '0 : pos_inc[ADDR_W-1:0];
        n_rot   = (is_last && !r_blend_mode) ? store_of(r_rot, ROLE_BACK3) : r_rot;
        n_wsel  = r_blend_mode ? store_of(r_rot, ROLE_BACK1) : store_of(r_rot, ROLE_BACK3);

        if (r_clr_busy) begin
            wr_en   = 3'b111;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                wr_en[k] = s1_adv & (r_s1_wsel == t_store_sel'(k));
            end
            wr_addr = r_s1_addr;
            wr_data = r_s1_pix;
        end
        for (int k = 0; k < 3; k++) begin
            n_hit[k] = wr_en[k] & (wr_addr == r_pos);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_store
            logic [PIXEL_BITS-1:0] r_mem [MAX_FRAME_PIXELS];

            always_ff @(posedge i_clk) begin
                if (wr_en[g]) begin
                    r_mem[wr_addr] <= wr_data;
                end
                if (in_acc) begin
                    r_rd[g] <= r_mem[r_pos];
                end
            end

            assign p_phys[g] = r_hit[g] ? r_fwd : r_rd[g];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rot      <= 2'd0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_pos <= n_pos;
                r_rot <= n_rot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= i_pixel_in[PIXEL_BITS-1:0];
            r_s1_rot  <= r_rot;
            r_s1_mode <= r_blend_mode;
            r_s1_addr <= r_pos;
            r_s1_last <= is_last;
            r_s1_wsel <= n_wsel;
            r_hit     <= n_hit;
            r_fwd     <= wr_data;
        end
    end

    always_comb begin
        p1      = p_phys[store_of(r_s1_rot, ROLE_BACK1)];
        p2      = p_phys[store_of(r_s1_rot, ROLE_BACK2)];
        p3      = p_phys[store_of(r_s1_rot, ROLE_BACK3)];
        mask    = r_color_mask[PIXEL_BITS-1:0];
        avg     = ((r_s1_pix & mask) >> 1) + ((p1 & mask) >> 1);
        flicker = (p1 != p2) && (p3 != r_s1_pix) && ((r_s1_pix == p2) || (p1 == p3));
        n_out_pix = (r_s1_mode || flicker) ? avg : r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = PORT_PIX_W'(r_out_pix);
    assign o_frame_last = r_out_last;

endmodule

// ===== design/ifb_checker.sv =====
// ----------------------------------------------------------------------------
// Interframe blend filter checker
// Port-level assertions on reset, latency, back-pressure and output holding.
// ----------------------------------------------------------------------------
module ifb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_pixel_out,
    input logic        o_frame_last
);

    logic in_xfer;

    assign in_xfer = i_in_valid & ~o_in_stall;

    // The memory clearing pass keeps the input stalled right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // A result appears only after its input transfer has passed the compute stage and output registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_xfer, 2))
        else $error("result without matching input transfer");

    // With the output stalled and the compute stage just filled, input must stall.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && $past(i_rst_n) && $past(in_xfer)) |-> o_in_stall)
        else $error("input taken while pipeline is full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pixel_out) && $stable(o_frame_last)))
        else $error("stalled result changed");

endmodule

bind interframe_blend_filter ifb_checker u_ifb_checker (.*);
